// File: hw/rtl/xad_pkg.sv
// Shared constants, codes and helpers for the XOR archive stream deframer.
package xad_pkg;

  localparam int MAX_RECORDS = 256;
  localparam int REC_AW      = $clog2(MAX_RECORDS);
  localparam int TABLE_W     = 32;

  localparam int BYTE_W = 8;
  localparam int SEC_W  = 4;
  localparam int REC_W  = 9;
  localparam int OFF_W  = 8;
  localparam int STAT_W = 2;
  localparam int LEFT_W = 31;

  localparam logic [BYTE_W-1:0] KEY_RESET = 8'hF7;
  localparam logic [BYTE_W-1:0] FLAG_END  = 8'h80;
  localparam logic [BYTE_W-1:0] VER_BYTE  = 8'h00;

  // Stream sections (also the phase of the parser).
  localparam logic [SEC_W-1:0] PH_MAGIC   = 4'd0;
  localparam logic [SEC_W-1:0] PH_VERSION = 4'd1;
  localparam logic [SEC_W-1:0] PH_FLAG    = 4'd2;
  localparam logic [SEC_W-1:0] PH_NLEN    = 4'd3;
  localparam logic [SEC_W-1:0] PH_NAME    = 4'd4;
  localparam logic [SEC_W-1:0] PH_SIZE    = 4'd5;
  localparam logic [SEC_W-1:0] PH_TIME    = 4'd6;
  localparam logic [SEC_W-1:0] PH_BODY    = 4'd7;
  localparam logic [SEC_W-1:0] PH_TRAIL   = 4'd8;

  // Sticky status codes.
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW    = 2'd3;

  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'hC0;
      2'd1:    b = 8'h4A;
      2'd2:    b = 8'hC0;
      2'd3:    b = 8'hBA;
      default: b = 8'hC0;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/xor_archive_stream_deframer_core.sv
// Top level of the XOR archive stream deframer: decode, parse and tag one byte per transfer.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------------
//  in_     | slave     | tdata[7:0] raw_byte
//  out_    | master    | tdata data/record/offset/status, tuser section/header_done, tlast
//  cfg_    | slave     | data[7:0] xor_key, always ready
//
// One byte per cycle through the parser; the result sits in an output register, and a
// new byte is taken only when that register is empty or drained in the same cycle.
// After the end-of-header flag and after the last byte of each body record, the size
// table RAM is scanned for the next usable record with input stalled: each table entry
// visited is read, then checked, and a final read state ends the scan when none is left.
// Reset (rst_n, synchronous) clears control state; the size table needs none.
module xor_archive_stream_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [16:8] record_number,
                                  // [24:17] field_offset, [26:25] status, rest zero
  output logic [4:0]  out_tuser,  // [3:0] section, [4] header_done
  output logic        out_tlast,  // record_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] xor_key
);

  localparam logic [1:0] CTL_RUN      = 2'd0;
  localparam logic [1:0] CTL_SEEK_RD  = 2'd1;
  localparam logic [1:0] CTL_SEEK_CHK = 2'd2;

  logic [1:0]                    ctl_r, ctl_nxt;
  logic [xad_pkg::BYTE_W-1:0]    key_r;
  logic [xad_pkg::SEC_W-1:0]     phase_r, phase_nxt;
  logic [xad_pkg::OFF_W-1:0]     byte_count_r, byte_count_nxt;
  logic [xad_pkg::BYTE_W-1:0]    name_length_r, name_length_nxt;
  logic [xad_pkg::REC_W-1:0]     records_seen_r, records_seen_nxt;
  logic [xad_pkg::REC_W-1:0]     body_index_r, body_index_nxt;
  logic [23:0]                   size_gather_r, size_gather_nxt;
  logic [xad_pkg::LEFT_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic [xad_pkg::STAT_W-1:0]    error_code_r, error_code_nxt;

  logic                          out_valid_r;
  logic [xad_pkg::BYTE_W-1:0]    o_data_r;
  logic [xad_pkg::SEC_W-1:0]     o_sec_r, o_sec;
  logic [xad_pkg::REC_W-1:0]     o_rec_r, o_rec;
  logic [xad_pkg::OFF_W-1:0]     o_off_r, o_off;
  logic                          o_hdone_r, o_hdone;
  logic                          o_rlast_r, o_rlast;
  logic [xad_pkg::STAT_W-1:0]    o_stat_r;

  logic                          accept;
  logic [xad_pkg::BYTE_W-1:0]    d;
  logic [1:0]                    idx4;
  logic [xad_pkg::OFF_W-1:0]     cnt_inc;
  logic [xad_pkg::BYTE_W-1:0]    want;
  logic [xad_pkg::LEFT_W-1:0]    left_dec;

  logic                          tbl_we;
  logic [xad_pkg::REC_AW-1:0]    tbl_waddr;
  logic [xad_pkg::TABLE_W-1:0]   tbl_wdata;
  logic [xad_pkg::REC_AW-1:0]    tbl_raddr;
  logic [xad_pkg::TABLE_W-1:0]   tbl_rdata;

  assign cfg_ready = 1'b1;
  assign in_tready = (ctl_r == CTL_RUN) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign d         = in_tdata ^ key_r;
  assign idx4      = byte_count_r[1:0];
  assign cnt_inc   = byte_count_r + 8'd1;
  assign left_dec  = (bytes_left_r != '0) ? bytes_left_r - 31'd1 : bytes_left_r;

  // Writes only happen while parsing the header and read data is only used while scanning after it,
  // so the table never sees a read and a write of the same entry in flight.
  assign tbl_waddr = records_seen_r[xad_pkg::REC_AW-1:0];
  assign tbl_wdata = {d, size_gather_r};
  assign tbl_raddr = body_index_r[xad_pkg::REC_AW-1:0];

  xad_ram #(
    .WIDTH(xad_pkg::TABLE_W),
    .DEPTH(xad_pkg::MAX_RECORDS)
  ) u_size_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_comb begin
    ctl_nxt          = ctl_r;
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    name_length_nxt  = name_length_r;
    records_seen_nxt = records_seen_r;
    body_index_nxt   = body_index_r;
    size_gather_nxt  = size_gather_r;
    bytes_left_nxt   = bytes_left_r;
    error_code_nxt   = error_code_r;
    tbl_we           = 1'b0;
    o_sec            = phase_r;
    o_rec            = '0;
    o_off            = '0;
    o_hdone          = 1'b0;
    o_rlast          = 1'b0;
    want             = (phase_r == xad_pkg::PH_MAGIC) ? xad_pkg::magic_byte(idx4)
                                                      : xad_pkg::VER_BYTE;

    case (ctl_r)
      CTL_RUN: begin
        if (accept) begin
          case (phase_r)
            xad_pkg::PH_MAGIC, xad_pkg::PH_VERSION: begin
              o_off = {6'd0, idx4};
              if (d != want) begin
                if (error_code_r == xad_pkg::ST_OK) begin
                  error_code_nxt = (phase_r == xad_pkg::PH_MAGIC) ?
                                   xad_pkg::ST_BAD_MAGIC : xad_pkg::ST_BAD_VERSION;
                end
                phase_nxt = xad_pkg::PH_TRAIL;
              end else if (idx4 == 2'd3) begin
                byte_count_nxt = '0;
                phase_nxt = (phase_r == xad_pkg::PH_MAGIC) ? xad_pkg::PH_VERSION
                                                           : xad_pkg::PH_FLAG;
              end else begin
                byte_count_nxt = {6'd0, idx4 + 2'd1};
              end
            end
            xad_pkg::PH_FLAG: begin
              o_rec = records_seen_r;
              if (d == xad_pkg::FLAG_END) begin
                o_hdone        = 1'b1;
                body_index_nxt = '0;
                ctl_nxt        = CTL_SEEK_RD;
              end else if (records_seen_r >= xad_pkg::REC_W'(xad_pkg::MAX_RECORDS)) begin
                if (error_code_r == xad_pkg::ST_OK) begin
                  error_code_nxt = xad_pkg::ST_OVERFLOW;
                end
                phase_nxt = xad_pkg::PH_TRAIL;
              end else begin
                phase_nxt = xad_pkg::PH_NLEN;
              end
            end
            xad_pkg::PH_NLEN: begin
              o_rec           = records_seen_r;
              name_length_nxt = d;
              byte_count_nxt  = '0;
              size_gather_nxt = '0;
              phase_nxt       = (d == 8'd0) ? xad_pkg::PH_SIZE : xad_pkg::PH_NAME;
            end
            xad_pkg::PH_NAME: begin
              o_rec          = records_seen_r;
              o_off          = byte_count_r;
              byte_count_nxt = cnt_inc;
              if (cnt_inc >= name_length_r) begin
                byte_count_nxt  = '0;
                size_gather_nxt = '0;
                phase_nxt       = xad_pkg::PH_SIZE;
              end
            end
            xad_pkg::PH_SIZE: begin
              o_rec = records_seen_r;
              o_off = {6'd0, idx4};
              case (idx4)
                2'd0:    size_gather_nxt[7:0]   = d;
                2'd1:    size_gather_nxt[15:8]  = d;
                2'd2:    size_gather_nxt[23:16] = d;
                default: size_gather_nxt        = size_gather_r;
              endcase
              if (idx4 == 2'd3) begin
                tbl_we         = (records_seen_r < xad_pkg::REC_W'(xad_pkg::MAX_RECORDS));
                byte_count_nxt = '0;
                phase_nxt      = xad_pkg::PH_TIME;
              end else begin
                byte_count_nxt = {6'd0, idx4 + 2'd1};
              end
            end
            xad_pkg::PH_TIME: begin
              o_rec = records_seen_r;
              o_off = {5'd0, byte_count_r[2:0]};
              if (byte_count_r[2:0] == 3'd7) begin
                byte_count_nxt   = '0;
                records_seen_nxt = records_seen_r + 9'd1;
                phase_nxt        = xad_pkg::PH_FLAG;
              end else begin
                byte_count_nxt = {5'd0, byte_count_r[2:0] + 3'd1};
              end
            end
            xad_pkg::PH_BODY: begin
              o_rec          = body_index_r;
              o_off          = byte_count_r;
              byte_count_nxt = cnt_inc;
              bytes_left_nxt = left_dec;
              if (left_dec == '0) begin
                o_rlast        = 1'b1;
                body_index_nxt = body_index_r + 9'd1;
                ctl_nxt        = CTL_SEEK_RD;
              end
            end
            default: begin
              o_sec     = xad_pkg::PH_TRAIL;
              phase_nxt = xad_pkg::PH_TRAIL;
            end
          endcase
        end
      end
      CTL_SEEK_RD: begin
        // Table read is issued at body_index_r; data arrives next cycle.
        if (body_index_r >= records_seen_r) begin
          phase_nxt = xad_pkg::PH_TRAIL;
          ctl_nxt   = CTL_RUN;
        end else begin
          ctl_nxt = CTL_SEEK_CHK;
        end
      end
      CTL_SEEK_CHK: begin
        if (tbl_rdata != '0 && !tbl_rdata[31]) begin
          bytes_left_nxt = tbl_rdata[30:0];
          byte_count_nxt = '0;
          phase_nxt      = xad_pkg::PH_BODY;
          ctl_nxt        = CTL_RUN;
        end else begin
          body_index_nxt = body_index_r + 9'd1;
          ctl_nxt        = CTL_SEEK_RD;
        end
      end
      default: begin
        ctl_nxt = CTL_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r          <= CTL_RUN;
      key_r          <= xad_pkg::KEY_RESET;
      phase_r        <= xad_pkg::PH_MAGIC;
      byte_count_r   <= '0;
      name_length_r  <= '0;
      records_seen_r <= '0;
      body_index_r   <= '0;
      size_gather_r  <= '0;
      bytes_left_r   <= '0;
      error_code_r   <= xad_pkg::ST_OK;
      out_valid_r    <= 1'b0;
    end else begin
      ctl_r          <= ctl_nxt;
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      name_length_r  <= name_length_nxt;
      records_seen_r <= records_seen_nxt;
      body_index_r   <= body_index_nxt;
      size_gather_r  <= size_gather_nxt;
      bytes_left_r   <= bytes_left_nxt;
      error_code_r   <= error_code_nxt;
      if (cfg_valid && cfg_ready) begin
        key_r <= cfg_data;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; status reflects the error code after this byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      o_data_r  <= d;
      o_sec_r   <= o_sec;
      o_rec_r   <= o_rec;
      o_off_r   <= o_off;
      o_hdone_r <= o_hdone;
      o_rlast_r <= o_rlast;
      o_stat_r  <= error_code_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, o_stat_r, o_off_r, o_rec_r, o_data_r};
  assign out_tuser  = {o_hdone_r, o_sec_r};
  assign out_tlast  = o_rlast_r;

endmodule

// File: hw/rtl/xad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module xad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
